### src/nalsc_pkg.sv
// Package for the NAL unit start-code splitter.
// Holds the field widths, constants and payload types used by every module.
package nalsc_pkg;

   localparam int MAX_BUFFER_BYTES_DEFAULT = 1048576;
   localparam int QUEUE_DEPTH_DEFAULT      = 4;

   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 20;
   localparam int SIZE_W      = 21;
   localparam int CODE_LEN_W  = 3;
   localparam int TYPE_W      = 5;
   localparam int COUNT_W     = 8;

   localparam logic [COUNT_W-1:0]    MAX_UNITS_RESET = 8'd100;
   localparam logic [CODE_LEN_W-1:0] CODE_LEN_SHORT  = 3'd3;
   localparam logic [CODE_LEN_W-1:0] CODE_LEN_LONG   = 3'd4;
   localparam logic [BYTE_W-1:0]     START_BYTE      = 8'h01;
   localparam logic [BYTE_W-1:0]     ZERO_BYTE       = 8'h00;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic                  unit_valid;
      logic [OFFSET_W-1:0]   unit_offset;
      logic [SIZE_W-1:0]     unit_size;
      logic [CODE_LEN_W-1:0] start_code_len;
      logic [TYPE_W-1:0]     unit_type;
      logic [SIZE_W-1:0]     payload_len;
      logic [COUNT_W-1:0]    unit_number;
      logic                  last_of_buffer;
   } rsp_type;

   typedef struct packed {
      logic                  unit_valid;
      logic [OFFSET_W-1:0]   unit_offset;
      logic [SIZE_W-1:0]     unit_size;
      logic [CODE_LEN_W-1:0] start_code_len;
      logic [TYPE_W-1:0]     unit_type;
      logic [COUNT_W-1:0]    unit_number;
      logic                  last_of_buffer;
   } rec_type;

   typedef struct packed {
      logic [1:0] rec_count;
      rec_type    rec0;
      rec_type    rec1;
   } entry_type;

endpackage

### src/nalsc_front.sv
// Front end of the start-code splitter: byte scan, start-code detection, unit bookkeeping.
// Builds up to two records per byte into one queue entry. Depends on nalsc_pkg.
module nalsc_front #(
   parameter int MAX_BUFFER_BYTES = nalsc_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  nalsc_pkg::req_type                 req_data,
   input  logic                               csr_wr_en,
   input  logic [nalsc_pkg::COUNT_W-1:0]      csr_wr_data,
   output logic                               push,
   output nalsc_pkg::entry_type               push_entry
);

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES);
   localparam int OW    = nalsc_pkg::OFFSET_W;
   localparam int SW    = nalsc_pkg::SIZE_W;
   localparam int CW    = nalsc_pkg::COUNT_W;
   localparam int TW    = nalsc_pkg::TYPE_W;
   localparam int LW    = nalsc_pkg::CODE_LEN_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BUFFER_BYTES - 1);

   logic [1:0]       zero_run_ff, zero_run_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] open_off_ff, open_off_in;
   logic [LW-1:0]    open_clen_ff, open_clen_in;
   logic [TW-1:0]    open_type_ff, open_type_in;
   logic             type_pending_ff, type_pending_in;
   logic             unit_open_ff, unit_open_in;
   logic [CW-1:0]    units_found_ff, units_found_in;
   logic [CW-1:0]    max_units_ff, max_units_in;

   logic [TW-1:0]    type_now;
   logic             detect;
   logic [LW-1:0]    clen_new;
   logic [POS_W-1:0] code_back;
   logic [POS_W-1:0] new_off;
   logic [POS_W:0]   size_a;
   logic [POS_W-1:0] off_after;
   logic [LW-1:0]    clen_after;
   logic [TW-1:0]    type_after;
   logic             open_after;
   logic [CW-1:0]    found_after;
   logic [POS_W:0]   end_pos;
   logic [POS_W:0]   size_b;
   logic [POS_W+OW-1:0] off_a_wide, off_b_wide;
   logic [POS_W+SW:0]   size_a_wide, size_b_wide;
   nalsc_pkg::rec_type  rec_a, rec_b;

   always_comb begin
      type_now  = type_pending_ff ? req_data.byte_value[TW-1:0] : open_type_ff;
      detect    = (req_data.byte_value == nalsc_pkg::START_BYTE) && (zero_run_ff >= 2'd2)
                  && (units_found_ff < max_units_ff);
      clen_new  = (zero_run_ff == 2'd3) ? nalsc_pkg::CODE_LEN_LONG : nalsc_pkg::CODE_LEN_SHORT;
      code_back = (zero_run_ff == 2'd3) ? POS_W'(3) : POS_W'(2);
      new_off   = (pos_ff >= code_back) ? (pos_ff - code_back) : '0;
      size_a    = (new_off > open_off_ff) ? {1'b0, new_off - open_off_ff} : '0;

      off_after   = detect ? new_off : open_off_ff;
      clen_after  = detect ? clen_new : open_clen_ff;
      type_after  = detect ? '0 : type_now;
      open_after  = detect | unit_open_ff;
      found_after = detect ? (units_found_ff + CW'(1)) : units_found_ff;

      end_pos = {1'b0, pos_ff} + (POS_W+1)'(1);
      size_b  = (end_pos > {1'b0, off_after}) ? (end_pos - {1'b0, off_after}) : '0;

      off_a_wide  = {{OW{1'b0}}, open_off_ff};
      off_b_wide  = {{OW{1'b0}}, off_after};
      size_a_wide = {{SW{1'b0}}, size_a};
      size_b_wide = {{SW{1'b0}}, size_b};

      rec_a.unit_valid     = 1'b1;
      rec_a.unit_offset    = off_a_wide[OW-1:0];
      rec_a.unit_size      = size_a_wide[SW-1:0];
      rec_a.start_code_len = open_clen_ff;
      rec_a.unit_type      = type_now;
      rec_a.unit_number    = units_found_ff - CW'(1);
      rec_a.last_of_buffer = 1'b0;

      if (open_after) begin
         rec_b.unit_valid     = 1'b1;
         rec_b.unit_offset    = off_b_wide[OW-1:0];
         rec_b.unit_size      = size_b_wide[SW-1:0];
         rec_b.start_code_len = clen_after;
         rec_b.unit_type      = type_after;
         rec_b.unit_number    = found_after - CW'(1);
      end else begin
         rec_b.unit_valid     = 1'b0;
         rec_b.unit_offset    = '0;
         rec_b.unit_size      = '0;
         rec_b.start_code_len = '0;
         rec_b.unit_type      = '0;
         rec_b.unit_number    = '0;
      end
      rec_b.last_of_buffer = 1'b1;

      if (detect && unit_open_ff) begin
         push_entry.rec_count = req_data.last_byte ? 2'd2 : 2'd1;
         push_entry.rec0      = rec_a;
         push_entry.rec1      = rec_b;
      end else begin
         push_entry.rec_count = req_data.last_byte ? 2'd1 : 2'd0;
         push_entry.rec0      = rec_b;
         push_entry.rec1      = rec_b;
      end
      push = accept && (push_entry.rec_count != 2'd0);

      zero_run_in     = zero_run_ff;
      pos_in          = pos_ff;
      open_off_in     = open_off_ff;
      open_clen_in    = open_clen_ff;
      open_type_in    = open_type_ff;
      type_pending_in = type_pending_ff;
      unit_open_in    = unit_open_ff;
      units_found_in  = units_found_ff;
      max_units_in    = csr_wr_en ? csr_wr_data : max_units_ff;

      if (accept) begin
         if (req_data.last_byte) begin
            zero_run_in     = '0;
            pos_in          = '0;
            open_off_in     = '0;
            open_clen_in    = '0;
            open_type_in    = '0;
            type_pending_in = 1'b0;
            unit_open_in    = 1'b0;
            units_found_in  = '0;
         end else begin
            if (req_data.byte_value == nalsc_pkg::ZERO_BYTE) begin
               zero_run_in = (zero_run_ff == 2'd3) ? zero_run_ff : zero_run_ff + 2'd1;
            end else begin
               zero_run_in = '0;
            end
            pos_in          = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : pos_ff;
            open_off_in     = off_after;
            open_clen_in    = clen_after;
            open_type_in    = type_after;
            type_pending_in = detect;
            unit_open_in    = open_after;
            units_found_in  = found_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff     <= '0;
         pos_ff          <= '0;
         open_off_ff     <= '0;
         open_clen_ff    <= '0;
         open_type_ff    <= '0;
         type_pending_ff <= 1'b0;
         unit_open_ff    <= 1'b0;
         units_found_ff  <= '0;
         max_units_ff    <= nalsc_pkg::MAX_UNITS_RESET;
      end else begin
         zero_run_ff     <= zero_run_in;
         pos_ff          <= pos_in;
         open_off_ff     <= open_off_in;
         open_clen_ff    <= open_clen_in;
         open_type_ff    <= open_type_in;
         type_pending_ff <= type_pending_in;
         unit_open_ff    <= unit_open_in;
         units_found_ff  <= units_found_in;
         max_units_ff    <= max_units_in;
      end
   end

endmodule

### src/nalsc_queue.sv
// Record queue between the front end and the back end of the start-code splitter.
// Circular buffer of entries; depth must be a power of two. Depends on nalsc_pkg.
module nalsc_queue #(
   parameter int QUEUE_DEPTH = nalsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  nalsc_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output nalsc_pkg::entry_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   nalsc_pkg::entry_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/nalsc_back.sv
// Back end of the start-code splitter: unpacks queue entries into single records.
// Derives the payload length and drives the result output register. Depends on nalsc_pkg.
module nalsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  nalsc_pkg::entry_type head,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output nalsc_pkg::rsp_type   rsp_data
);

   logic               sel_ff, sel_in;
   logic               valid_ff, valid_in;
   nalsc_pkg::rsp_type data_ff, data_in;
   nalsc_pkg::rec_type rec;
   logic               load;
   logic               entry_done;
   logic [nalsc_pkg::SIZE_W-1:0] clen_ext;

   always_comb begin
      rec        = sel_ff ? head.rec1 : head.rec0;
      load       = not_empty && (!valid_ff || !rsp_stall);
      entry_done = sel_ff || (head.rec_count == 2'd1);
      pop        = load && entry_done;
      clen_ext   = {{(nalsc_pkg::SIZE_W-nalsc_pkg::CODE_LEN_W){1'b0}}, rec.start_code_len};

      sel_in = sel_ff;
      if (load) begin
         sel_in = !entry_done;
      end

      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in               = 1'b1;
         data_in.unit_valid     = rec.unit_valid;
         data_in.unit_offset    = rec.unit_offset;
         data_in.unit_size      = rec.unit_size;
         data_in.start_code_len = rec.start_code_len;
         data_in.unit_type      = rec.unit_type;
         data_in.payload_len    = (rec.unit_size > clen_ext) ? rec.unit_size - clen_ext : '0;
         data_in.unit_number    = rec.unit_number;
         data_in.last_of_buffer = rec.last_of_buffer;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end

      rsp_valid = valid_ff;
      rsp_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

### src/nal_unit_start_code_splitter.sv
// Top level of the H.264 Annex B start-code splitter.
// Instantiates nalsc_front, nalsc_queue and nalsc_back; depends on nalsc_pkg.
//
// Scans an Annex B buffer one byte per clock on the req_ channel and emits one
// record per NAL unit on the rsp_ channel: offset, size, start-code length,
// type, payload length and unit index. A unit's record leaves once the next
// start code completes or on the buffer's last byte; a start code on the last
// byte while a unit is open gives two records, and a buffer with no start code
// gives one record with unit_valid low. Bytes are taken every clock while the
// record queue (QUEUE_DEPTH entries, each holding the records of one byte) has
// room; the result port moves one record per clock, so req_stall rises only
// when the consumer holds rsp_stall or two-record bytes arrive faster than the
// back end can unpack them. max_units may be written through csr_ only while
// the block is idle; it resets to 100.
module nal_unit_start_code_splitter #(
   parameter int MAX_BUFFER_BYTES = nalsc_pkg::MAX_BUFFER_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH      = nalsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  nalsc_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output nalsc_pkg::rsp_type            rsp_data,
   input  logic                          csr_wr_en,
   input  logic [nalsc_pkg::COUNT_W-1:0] csr_wr_data
);

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 full;
   logic                 not_empty;
   nalsc_pkg::entry_type push_entry;
   nalsc_pkg::entry_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   nalsc_front #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push       (push),
      .push_entry (push_entry)
   );

   nalsc_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   nalsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .not_empty(not_empty),
      .head     (head),
      .pop      (pop),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule
